// File: sv/brd_pkg.sv
package brd_pkg;

	typedef enum logic [3:0] {
		PH_IDENT = 4'd0,
		PH_ORIG  = 4'd1,
		PH_COMP  = 4'd2,
		PH_FLAG  = 4'd3,
		PH_VAR   = 4'd4,
		PH_REP   = 4'd5,
		PH_CMP   = 4'd6,
		PH_NONE  = 4'd7,
		PH_NREP  = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_DONE = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BT_NONE     = 3'd0,
		BT_ZERO     = 3'd1,
		BT_ZERO_VAR = 3'd2,
		BT_VAR_ZERO = 3'd3,
		BT_HIGH     = 3'd4,
		BT_HIGH_VAR = 3'd5,
		BT_VAR_HIGH = 3'd6,
		BT_VAR      = 3'd7
	} btype_t;

	localparam logic [3:0] VARINT_MAX = 4'd10;

	// expected identifier bytes
	function automatic logic [7:0] ident_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h43;
			3'd1: b = 8'h46;
			3'd2: b = 8'h47;
			3'd3: b = 8'h5F;
			3'd4: b = 8'h43;
			3'd5: b = 8'h4D;
			3'd6: b = 8'h50;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic is_single(input btype_t t);
		return (t == BT_ZERO) || (t == BT_HIGH) || (t == BT_VAR);
	endfunction

endpackage

// File: sv/brd_ram.sv
module brd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/bitstream_rle_decompressor_top.sv
// Configuration bitstream decompressor. Each item is either a push of one
// compressed byte (func 0) or a pull of one decompressed byte (func 1); every
// item produces exactly one result carrying byte_taken, out_valid, out_byte,
// status and wants_input. An item is accepted every cycle while the result
// side takes results, so the sustained rate is one item per clock. Decoding
// state lives in registers and one update is done per item in the accept
// cycle; the literal replay buffer is a one-port-write, one-port-read RAM
// whose registered read data lands in the output stage, so a replayed byte
// reaches out_byte in the cycle after its pull is accepted, like every other
// result. A push that writes the buffer and a pull that reads it never occur
// in the same block phase, so no forwarding is required. While a result
// waits in the output register, in_stall follows out_stall in the same
// cycle, so no item is taken until that result leaves. Errors are sticky
// until arst_n.
module bitstream_rle_decompressor_top
	import brd_pkg::*;
#(
	parameter int LITERAL_BUFFER_DEPTH = 256,
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] in_byte,
	output logic       out_valid_hs,
	input  logic       out_stall,
	output logic       byte_taken,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       wants_input
);

	localparam int AW = (LITERAL_BUFFER_DEPTH > 1) ? $clog2(LITERAL_BUFFER_DEPTH) : 1;
	localparam int RD = (LITERAL_BUFFER_DEPTH > 1) ? LITERAL_BUFFER_DEPTH : 2;
	localparam int CW = SIZE_BITS + 1;

	typedef struct packed {
		logic       taken;
		logic       valid;
		logic       from_ram;
		logic [7:0] data;
		logic [1:0] stat;
		logic       wants;
	} res_t;

	// decoder state
	phase_t              phase_q;
	status_t             status_q;
	logic [2:0]          hdr_cnt_q;
	logic [63:0]         vacc_q;
	logic [3:0]          vcnt_q;
	logic [SIZE_BITS-1:0] orig_q, comp_q, blen_q, bidx_q, rcnt_q, ridx_q, tin_q, tout_q;
	btype_t              btype_q;
	logic                brep_q;
	logic [7:0]          vbyte_q, fbyte_q;
	logic                vsent_q;
	logic [1:0]          track_q;

	phase_t              phase_d;
	status_t             status_d;
	logic [2:0]          hdr_cnt_d;
	logic [63:0]         vacc_d;
	logic [3:0]          vcnt_d;
	logic [SIZE_BITS-1:0] orig_d, comp_d, blen_d, bidx_d, rcnt_d, ridx_d, tin_d, tout_d;
	btype_t              btype_d;
	logic                brep_d;
	logic [7:0]          vbyte_d, fbyte_d;
	logic                vsent_d;
	logic [1:0]          track_d;

	// output stage
	res_t res_s1, res_d;
	logic v_s1;
	logic [7:0] ram_rdata, ram_hold_q;
	logic ram_hold_v_q;

	logic accept;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;

	assign in_stall = v_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	// buffer RAM
	brd_ram #(.WIDTH(8), .DEPTH(RD)) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one item of decode work
	always_comb begin
		logic [SIZE_BITS-1:0] tin1, tout1, bidx1, v;
		logic [63:0] acc;
		logic [3:0] vc;
		logic vdone, verr, emitted;
		logic [7:0] ob;

		phase_d = phase_q; status_d = status_q; hdr_cnt_d = hdr_cnt_q;
		vacc_d = vacc_q; vcnt_d = vcnt_q; orig_d = orig_q; comp_d = comp_q;
		blen_d = blen_q; bidx_d = bidx_q; rcnt_d = rcnt_q; ridx_d = ridx_q;
		tin_d = tin_q; tout_d = tout_q; btype_d = btype_q; brep_d = brep_q;
		vbyte_d = vbyte_q; fbyte_d = fbyte_q; vsent_d = vsent_q; track_d = track_q;
		res_d = '0;
		ram_we = 1'b0;
		ram_waddr = bidx_q[AW-1:0];
		ram_raddr = bidx_q[AW-1:0];
		ob = 8'h00;
		emitted = 1'b0;
		v = '0;

		tin1  = tin_q + 1'b1;
		tout1 = tout_q + 1'b1;
		bidx1 = bidx_q + 1'b1;

		// varint accumulate
		verr = (vcnt_q >= VARINT_MAX);
		acc = vacc_q | ({57'd0, in_byte[6:0]} << (vcnt_q * 7));
		vc = vcnt_q + 4'd1;
		vdone = !in_byte[7];

		if (status_d == ST_DONE) status_d = ST_ERR;
		if (status_d == ST_GOOD && phase_q != PH_IDENT && phase_q != PH_ORIG) begin
			if (tout_q >= orig_q) status_d = ST_ERR;
			else if (phase_q != PH_COMP && tin_q > comp_q) status_d = ST_ERR;
		end

		if (status_d == ST_GOOD) begin
			if (!func && phase_q != PH_CMP && phase_q != PH_NREP) begin
				res_d.taken = 1'b1;
				case (phase_q)
					PH_NONE: begin
						if (tin_q >= comp_q) begin
							res_d.taken = 1'b0;
							status_d = ST_ERR;
						end else begin
							res_d.valid = 1'b1;
							ob = in_byte;
							if (brep_q && {1'b0, bidx_q} < CW'(LITERAL_BUFFER_DEPTH))
								ram_we = 1'b1;
							bidx_d = bidx1;
							tin_d = tin1;
							tout_d = tout1;
							if (bidx1 >= blen_q) begin
								bidx_d = '0;
								if (tout1 == orig_q) begin
									if (brep_q) status_d = ST_ERR;
									else begin
										phase_d = PH_FLAG;
										status_d = (tin1 == comp_q) ? ST_DONE : ST_ERR;
									end
								end else begin
									phase_d = brep_q ? PH_REP : PH_FLAG;
								end
							end
						end
					end
					PH_IDENT: begin
						if (in_byte != ident_byte(hdr_cnt_q)) status_d = ST_ERR;
						else begin
							hdr_cnt_d = hdr_cnt_q + 3'd1;
							if (hdr_cnt_q == 3'd7) phase_d = PH_ORIG;
						end
					end
					PH_ORIG, PH_COMP: begin
						if (verr) status_d = ST_ERR;
						else if (vdone) begin
							vacc_d = '0; vcnt_d = '0;
							if (phase_q == PH_ORIG) begin
								orig_d = acc[SIZE_BITS-1:0]; phase_d = PH_COMP;
							end else begin
								comp_d = acc[SIZE_BITS-1:0]; phase_d = PH_FLAG;
							end
						end else begin
							vacc_d = acc; vcnt_d = vc;
						end
					end
					PH_FLAG: begin
						if (verr) status_d = ST_ERR;
						else begin
							tin_d = tin1;
							if (vdone) begin
								vacc_d = '0; vcnt_d = '0;
								btype_d = btype_t'(acc[2:0]);
								brep_d = acc[3];
								v = SIZE_BITS'(acc >> 4);
								blen_d = v;
								bidx_d = '0; ridx_d = '0; fbyte_d = 8'h00; vsent_d = 1'b0;
								track_d = is_single(btype_t'(acc[2:0])) ? 2'd1 : 2'd0;
								if (v == '0) status_d = ST_ERR;
								else if (acc[3] && is_single(btype_t'(acc[2:0])))
									status_d = ST_ERR;
								else begin
									if (acc[2:0] == BT_HIGH || acc[2:0] == BT_HIGH_VAR ||
										acc[2:0] == BT_VAR_HIGH)
										fbyte_d = 8'hFF;
									if (acc[2:0] == BT_NONE) begin
										if (acc[3] && {1'b0, v} > CW'(LITERAL_BUFFER_DEPTH))
											status_d = ST_ERR;
										else phase_d = PH_NONE;
									end else if (acc[2:0] == BT_ZERO || acc[2:0] == BT_HIGH)
										phase_d = PH_CMP;
									else phase_d = PH_VAR;
								end
							end else begin
								vacc_d = acc; vcnt_d = vc;
							end
						end
					end
					PH_VAR: begin
						vbyte_d = in_byte;
						tin_d = tin1;
						if (btype_q == BT_VAR) fbyte_d = in_byte;
						phase_d = brep_q ? PH_REP : PH_CMP;
					end
					PH_REP: begin
						if (verr) status_d = ST_ERR;
						else begin
							tin_d = tin1;
							if (vdone) begin
								vacc_d = '0; vcnt_d = '0;
								rcnt_d = acc[SIZE_BITS-1:0];
								if (acc[SIZE_BITS-1:0] == '0) status_d = ST_ERR;
								else phase_d = (btype_q == BT_NONE) ? PH_NREP : PH_CMP;
							end else begin
								vacc_d = acc; vcnt_d = vc;
							end
						end
					end
					default: status_d = ST_ERR;
				endcase
			end else if (func && phase_q == PH_CMP) begin
				// fill run with optional variable byte
				if (!vsent_q && (btype_q == BT_VAR_ZERO || btype_q == BT_VAR_HIGH)) begin
					vsent_d = 1'b1; ob = vbyte_q; track_d = track_q | 2'd1; emitted = 1'b1;
				end else if (bidx_q < blen_q) begin
					ob = fbyte_q; bidx_d = bidx1; emitted = 1'b1;
					if (bidx1 == blen_q) track_d = track_q | 2'd2;
				end else if (!vsent_q && (btype_q == BT_ZERO_VAR || btype_q == BT_HIGH_VAR)) begin
					vsent_d = 1'b1; ob = vbyte_q; track_d = track_q | 2'd1; emitted = 1'b1;
				end
				res_d.valid = emitted;
				if (emitted) tout_d = tout1;
				if (track_d == 2'd3) begin
					track_d = is_single(btype_q) ? 2'd1 : 2'd0;
					if (brep_q) begin
						vsent_d = 1'b0;
						bidx_d = '0;
						if (ridx_q >= rcnt_q) begin
							phase_d = PH_FLAG;
							if (tout_d == orig_q)
								status_d = (tin_q == comp_q) ? ST_DONE : ST_ERR;
						end
						ridx_d = ridx_q + 1'b1;
					end else begin
						phase_d = PH_FLAG;
						if (tout_d == orig_q)
							status_d = (tin_q == comp_q) ? ST_DONE : ST_ERR;
					end
				end
			end else if (func && phase_q == PH_NREP) begin
				// replay from the buffer
				res_d.valid = 1'b1;
				res_d.from_ram = {1'b0, bidx_q} < CW'(LITERAL_BUFFER_DEPTH);
				bidx_d = bidx1;
				tout_d = tout1;
				if (bidx1 >= blen_q) begin
					bidx_d = '0;
					ridx_d = ridx_q + 1'b1;
				end
				if (ridx_d >= rcnt_q) begin
					phase_d = PH_FLAG;
					if (tout1 == orig_q)
						status_d = (tin_q == comp_q) ? ST_DONE : ST_ERR;
				end
			end
		end

		res_d.data  = res_d.valid ? ob : 8'h00;
		res_d.stat  = status_d;
		res_d.wants = (status_d == ST_GOOD) && phase_d != PH_CMP && phase_d != PH_NREP;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDENT; status_q <= ST_GOOD; hdr_cnt_q <= '0;
			vacc_q <= '0; vcnt_q <= '0; orig_q <= '0; comp_q <= '0;
			blen_q <= '0; bidx_q <= '0; rcnt_q <= '0; ridx_q <= '0;
			tin_q <= '0; tout_q <= '0; btype_q <= BT_NONE; brep_q <= 1'b0;
			vbyte_q <= '0; fbyte_q <= '0; vsent_q <= 1'b0; track_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d; status_q <= status_d; hdr_cnt_q <= hdr_cnt_d;
			vacc_q <= vacc_d; vcnt_q <= vcnt_d; orig_q <= orig_d; comp_q <= comp_d;
			blen_q <= blen_d; bidx_q <= bidx_d; rcnt_q <= rcnt_d; ridx_q <= ridx_d;
			tin_q <= tin_d; tout_q <= tout_d; btype_q <= btype_d; brep_q <= brep_d;
			vbyte_q <= vbyte_d; fbyte_q <= fbyte_d; vsent_q <= vsent_d; track_q <= track_d;
		end
	end

	// output register; ram data held once the stage stalls
	logic [7:0] s1_data;
	assign s1_data = res_s1.from_ram ? (ram_hold_v_q ? ram_hold_q : ram_rdata) : res_s1.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ram_hold_v_q <= 1'b0;
		end else begin
			if (!v_s1 || !out_stall) begin
				v_s1 <= accept;
				ram_hold_v_q <= 1'b0;
			end else begin
				ram_hold_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!v_s1 || !out_stall) begin
			res_s1 <= res_d;
		end else begin
			if (!ram_hold_v_q) ram_hold_q <= ram_rdata;
		end
	end

	assign out_valid_hs = v_s1;
	assign byte_taken   = res_s1.taken;
	assign out_valid    = res_s1.valid;
	assign out_byte     = res_s1.valid ? s1_data : 8'h00;
	assign status       = res_s1.stat;
	assign wants_input  = res_s1.wants;

endmodule
